>>> design/tsct_pkg.sv
// ----------------------------------------------------------------------------
// tsct_pkg: shared types for the server connection table
// Operation, state, status and segment codes, the entry word kept in RAM,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tsct_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_ACCEPT  = 3'd1,
    OP_CLOSE   = 3'd2,
    OP_SEGMENT = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    LS_CLOSED    = 2'd0,
    LS_LISTENING = 2'd1,
    LS_CONNECTED = 2'd2,
    LS_CLOSEWAIT = 2'd3
  } link_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TABLE_FULL  = 3'd1,
    ST_UNUSED_SOCK = 3'd2,
    ST_WRONG_STATE = 3'd3,
    ST_UNKNOWN     = 3'd4,
    ST_IGNORED     = 3'd5
  } status_t;

  localparam logic [2:0] SEG_SYN = 3'd0;
  localparam logic [2:0] SEG_FIN = 3'd2;

  localparam logic REPLY_SYNACK = 1'b0;
  localparam logic REPLY_FINACK = 1'b1;

  localparam logic [15:0] WAIT_MAX = 16'hFFFF;

  // One table entry as stored in the entry RAM.
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] peer;
    link_t       ls;
    logic [15:0] wait_cnt;
    logic [15:0] own;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [2:0]  idx;
    link_t       cs;
    logic        rv;
    logic        rt;
    logic [15:0] rsrc;
    logic [15:0] rdst;
  } res_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CREATE,
    ACT_FULL,
    ACT_SOCK_BAD,
    ACT_SOCK,
    ACT_SEG,
    ACT_MISS,
    ACT_TICK,
    ACT_TICK_DONE,
    ACT_UNKNOWN
  } act_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DISPATCH,
    C_CREATE,
    C_SOCK,
    C_SEG,
    C_TICK,
    C_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic scan_en;
    logic rd_sidx;
    act_t act;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_end;
    logic cnt_free;
    logic sidx_ok;
    logic pend;
    logic match;
    logic slot_free;
  } sts_t;

  function automatic logic [2:0] low3(input logic [6:0] v);
    return v[2:0];
  endfunction

endpackage

>>> design/transport_server_connection_table.sv
// ----------------------------------------------------------------------------
// transport_server_connection_table: server connection table
// Creates, accepts and closes server entries, matches arriving control
// segments by port and answers with SYNACK or FINACK, and ages close-wait
// entries on each tick.
//
//   Channel | Handshake         | Contents
//   --------+-------------------+---------------------------------------------
//   in      | in_valid/in_stall | operation, socket index, ports, segment
//   out     | out_valid/out_stall | status, entry, state, reply segment
//   cfg     | cfg_valid/cfg_ready | close-wait tick limit (16 bit)
//
// A request is taken only when the sequencer is idle. Create scans the used
// bits for a free entry; segment and tick walk the entry RAM one entry per
// cycle with its registered read; accept and close access the addressed entry.
// The next request is taken in the cycle after the result is loaded.
// Reset clears the used bits, so no clearing pass of the entry RAM is needed.
// A result waits in the output register while the next request is worked on;
// a stall of out only holds back the following result.
// ----------------------------------------------------------------------------
module transport_server_connection_table #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [2:0]  in_socket_index,
  input  logic [15:0] in_server_port,
  input  logic [2:0]  in_seg_type,
  input  logic [15:0] in_seg_src_port,
  input  logic [15:0] in_seg_dest_port,
  input  logic [31:0] in_seg_seq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_entry_index,
  output logic [1:0]  out_conn_state,
  output logic        out_reply_valid,
  output logic        out_reply_type,
  output logic [15:0] out_reply_src_port,
  output logic [15:0] out_reply_dest_port,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  tsct_pkg::cmd_t cmd;
  tsct_pkg::sts_t sts;
  tsct_pkg::res_t res;

  tsct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_valid         (in_valid),
    .in_operation     (in_operation),
    .in_socket_index  (in_socket_index),
    .in_server_port   (in_server_port),
    .in_seg_type      (in_seg_type),
    .in_seg_src_port  (in_seg_src_port),
    .in_seg_dest_port (in_seg_dest_port),
    .in_seg_seq       (in_seg_seq),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_res          (res)
  );

  assign in_stall            = !cmd.take;
  assign cfg_ready           = 1'b1;
  assign out_status          = res.status;
  assign out_entry_index     = res.idx;
  assign out_conn_state      = res.cs;
  assign out_reply_valid     = res.rv;
  assign out_reply_type      = res.rt;
  assign out_reply_src_port  = res.rsrc;
  assign out_reply_dest_port = res.rdst;

endmodule

>>> design/tsct_ram.sv
// ----------------------------------------------------------------------------
// tsct_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/tsct_ctrl.sv
// ----------------------------------------------------------------------------
// tsct_ctrl: sequencer for the connection table
// Steps each request through dispatch, an entry scan or a single entry
// access, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tsct_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  tsct_pkg::sts_t       sts,
  output tsct_pkg::cmd_t       cmd
);

  tsct_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsct_pkg::C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tsct_pkg::C_IDLE: begin
        if (in_valid) state_nxt = tsct_pkg::C_DISPATCH;
      end
      tsct_pkg::C_DISPATCH: begin
        unique case (sts.op)
          tsct_pkg::OP_CREATE:  state_nxt = tsct_pkg::C_CREATE;
          tsct_pkg::OP_ACCEPT,
          tsct_pkg::OP_CLOSE:   state_nxt = sts.sidx_ok ? tsct_pkg::C_SOCK
                                                        : tsct_pkg::C_FINISH;
          tsct_pkg::OP_SEGMENT: state_nxt = tsct_pkg::C_SEG;
          tsct_pkg::OP_TICK:    state_nxt = tsct_pkg::C_TICK;
          default:              state_nxt = tsct_pkg::C_FINISH;
        endcase
      end
      tsct_pkg::C_CREATE: begin
        if (sts.cnt_end || sts.cnt_free) state_nxt = tsct_pkg::C_FINISH;
      end
      tsct_pkg::C_SOCK: begin
        state_nxt = tsct_pkg::C_FINISH;
      end
      tsct_pkg::C_SEG: begin
        if ((sts.pend && sts.match) || (!sts.pend && sts.cnt_end)) begin
          state_nxt = tsct_pkg::C_FINISH;
        end
      end
      tsct_pkg::C_TICK: begin
        if (!sts.pend && sts.cnt_end) state_nxt = tsct_pkg::C_FINISH;
      end
      tsct_pkg::C_FINISH: begin
        if (sts.slot_free) state_nxt = tsct_pkg::C_IDLE;
      end
      default: state_nxt = tsct_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{take: 1'b0, scan_en: 1'b0, rd_sidx: 1'b0,
            act: tsct_pkg::ACT_NONE, out_load: 1'b0};
    unique case (state_r)
      tsct_pkg::C_IDLE: begin
        cmd.take = 1'b1;
      end
      tsct_pkg::C_DISPATCH: begin
        unique case (sts.op)
          tsct_pkg::OP_CREATE,
          tsct_pkg::OP_SEGMENT,
          tsct_pkg::OP_TICK: begin
          end
          tsct_pkg::OP_ACCEPT,
          tsct_pkg::OP_CLOSE: begin
            if (sts.sidx_ok) begin
              cmd.rd_sidx = 1'b1;
            end else begin
              cmd.act = tsct_pkg::ACT_SOCK_BAD;
            end
          end
          default: cmd.act = tsct_pkg::ACT_UNKNOWN;
        endcase
      end
      tsct_pkg::C_CREATE: begin
        priority if (sts.cnt_end) begin
          cmd.act = tsct_pkg::ACT_FULL;
        end else if (sts.cnt_free) begin
          cmd.act = tsct_pkg::ACT_CREATE;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      tsct_pkg::C_SOCK: begin
        cmd.act = tsct_pkg::ACT_SOCK;
      end
      tsct_pkg::C_SEG: begin
        priority if (sts.pend && sts.match) begin
          cmd.act = tsct_pkg::ACT_SEG;
        end else if (!sts.pend && sts.cnt_end) begin
          cmd.act = tsct_pkg::ACT_MISS;
        end else begin
          cmd.scan_en = 1'b1;
        end
      end
      tsct_pkg::C_TICK: begin
        priority if (!sts.pend && sts.cnt_end) begin
          cmd.act = tsct_pkg::ACT_TICK_DONE;
        end else begin
          cmd.scan_en = 1'b1;
          if (sts.pend) cmd.act = tsct_pkg::ACT_TICK;
        end
      end
      tsct_pkg::C_FINISH: begin
        cmd.out_load = sts.slot_free;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/tsct_dp.sv
// ----------------------------------------------------------------------------
// tsct_dp: datapath of the connection table
// Request registers, used bits, the entry RAM with its scan counter, the
// per-operation update logic, the result and output registers.
// ----------------------------------------------------------------------------
module tsct_dp #(
  parameter int ENTRIES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsct_pkg::cmd_t       cmd,
  output tsct_pkg::sts_t       sts,
  input  logic                 in_valid,
  input  logic [2:0]           in_operation,
  input  logic [2:0]           in_socket_index,
  input  logic [15:0]          in_server_port,
  input  logic [2:0]           in_seg_type,
  input  logic [15:0]          in_seg_src_port,
  input  logic [15:0]          in_seg_dest_port,
  input  logic [31:0]          in_seg_seq,
  input  logic                 cfg_valid,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsct_pkg::res_t       out_res
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int EW   = $bits(tsct_pkg::entry_t);

  // Request registers
  tsct_pkg::op_t op_r;
  logic [2:0]    sidx_r;
  logic [15:0]   sport_r;
  logic [2:0]    stype_r;
  logic [15:0]   src_r;
  logic [15:0]   dst_r;
  logic [31:0]   seq_r;

  logic [15:0]        cfg_r;
  logic [ENTRIES-1:0] used_r, used_nxt;
  logic [CNTW-1:0]    cnt_r;
  logic               pend_r;
  logic [IW-1:0]      pidx_r;
  tsct_pkg::res_t     res_r, res_nxt;
  tsct_pkg::res_t     out_r;
  logic               out_valid_r;

  logic [IW-1:0]      cnt_i, sidx_i;
  logic               cnt_end, sidx_ok, slot_free, take;
  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  tsct_pkg::entry_t   ram_wdata, ram_rdata;
  logic [EW-1:0]      rdata_bits;
  logic [15:0]        wait_inc;
  tsct_pkg::res_t     res_zero;

  assign take      = cmd.take && in_valid;
  assign cnt_i     = cnt_r[IW-1:0];
  assign sidx_i    = IW'(sidx_r);
  assign cnt_end   = (cnt_r == CNTW'(ENTRIES));
  assign sidx_ok   = ({4'b0000, sidx_r} < 7'(ENTRIES)) && used_r[sidx_i];
  assign slot_free = !out_valid_r || !out_stall;
  assign ram_rdata = tsct_pkg::entry_t'(rdata_bits);
  assign res_zero  = '{status: tsct_pkg::ST_OK, idx: 3'd0, cs: tsct_pkg::LS_CLOSED,
                       rv: 1'b0, rt: 1'b0, rsrc: 16'd0, rdst: 16'd0};

  always_comb begin
    sts.op        = op_r;
    sts.cnt_end   = cnt_end;
    sts.cnt_free  = !cnt_end && !used_r[cnt_i];
    sts.sidx_ok   = sidx_ok;
    sts.pend      = pend_r;
    sts.match     = used_r[pidx_r] && (ram_rdata.own == dst_r);
    sts.slot_free = slot_free;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= tsct_pkg::op_t'(in_operation);
      sidx_r  <= in_socket_index;
      sport_r <= in_server_port;
      stype_r <= in_seg_type;
      src_r   <= in_seg_src_port;
      dst_r   <= in_seg_dest_port;
      seq_r   <= in_seg_seq;
    end
    if (cmd.scan_en && !cnt_end) begin
      pidx_r <= cnt_i;
    end
    res_r <= res_nxt;
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= 16'd1;
      used_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) cfg_r <= cfg_data;
      used_r <= used_nxt;
      if (take) begin
        cnt_r  <= '0;
        pend_r <= 1'b0;
      end else if (cmd.scan_en) begin
        pend_r <= !cnt_end;
        if (!cnt_end) cnt_r <= cnt_r + CNTW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Entry RAM: one read per scan step or for the addressed socket.
  assign ram_re    = (cmd.scan_en && !cnt_end) || cmd.rd_sidx;
  assign ram_raddr = cmd.rd_sidx ? sidx_i : cnt_i;

  tsct_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (EW'(ram_wdata)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata_bits)
  );

  assign wait_inc = (ram_rdata.wait_cnt < tsct_pkg::WAIT_MAX) ?
                    ram_rdata.wait_cnt + 16'd1 : ram_rdata.wait_cnt;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pidx_r;
    ram_wdata = ram_rdata;
    used_nxt  = used_r;
    res_nxt   = res_r;
    unique case (cmd.act)
      tsct_pkg::ACT_NONE: begin
      end
      tsct_pkg::ACT_CREATE: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_i;
        ram_wdata = '{seq: 32'd0, peer: 16'd0, ls: tsct_pkg::LS_CLOSED,
                      wait_cnt: 16'd0, own: sport_r};
        used_nxt[cnt_i] = 1'b1;
        res_nxt     = res_zero;
        res_nxt.idx = tsct_pkg::low3(7'(cnt_r));
      end
      tsct_pkg::ACT_FULL: begin
        res_nxt        = res_zero;
        res_nxt.status = tsct_pkg::ST_TABLE_FULL;
      end
      tsct_pkg::ACT_SOCK_BAD: begin
        res_nxt        = res_zero;
        res_nxt.status = tsct_pkg::ST_UNUSED_SOCK;
        res_nxt.idx    = sidx_r;
      end
      tsct_pkg::ACT_SOCK: begin
        res_nxt     = res_zero;
        res_nxt.idx = sidx_r;
        if (op_r == tsct_pkg::OP_ACCEPT) begin
          ram_we       = 1'b1;
          ram_waddr    = sidx_i;
          ram_wdata.ls = tsct_pkg::LS_LISTENING;
          res_nxt.cs   = tsct_pkg::LS_LISTENING;
        end else begin
          // Clearing the used bit frees the entry; its RAM word is dead.
          used_nxt[sidx_i] = 1'b0;
          if (ram_rdata.ls != tsct_pkg::LS_CLOSED) begin
            res_nxt.status = tsct_pkg::ST_WRONG_STATE;
          end
        end
      end
      tsct_pkg::ACT_SEG: begin
        res_nxt      = res_zero;
        res_nxt.idx  = tsct_pkg::low3(7'(pidx_r));
        res_nxt.rsrc = ram_rdata.own;
        res_nxt.rdst = src_r;
        priority if ((ram_rdata.ls == tsct_pkg::LS_LISTENING ||
                      ram_rdata.ls == tsct_pkg::LS_CONNECTED) &&
                     stype_r == tsct_pkg::SEG_SYN) begin
          ram_we         = 1'b1;
          ram_wdata.ls   = tsct_pkg::LS_CONNECTED;
          ram_wdata.peer = src_r;
          ram_wdata.seq  = seq_r;
          res_nxt.cs     = tsct_pkg::LS_CONNECTED;
          res_nxt.rv     = 1'b1;
          res_nxt.rt     = tsct_pkg::REPLY_SYNACK;
        end else if (ram_rdata.ls == tsct_pkg::LS_CONNECTED &&
                     stype_r == tsct_pkg::SEG_FIN) begin
          ram_we             = 1'b1;
          ram_wdata.ls       = tsct_pkg::LS_CLOSEWAIT;
          ram_wdata.wait_cnt = 16'd0;
          res_nxt.cs         = tsct_pkg::LS_CLOSEWAIT;
          res_nxt.rv         = 1'b1;
          res_nxt.rt         = tsct_pkg::REPLY_FINACK;
        end else if (ram_rdata.ls == tsct_pkg::LS_CLOSEWAIT &&
                     stype_r == tsct_pkg::SEG_FIN) begin
          // A repeated FIN only resends the FINACK; the counter keeps running.
          res_nxt.cs = tsct_pkg::LS_CLOSEWAIT;
          res_nxt.rv = 1'b1;
          res_nxt.rt = tsct_pkg::REPLY_FINACK;
        end else begin
          res_nxt.status = tsct_pkg::ST_IGNORED;
          res_nxt.cs     = ram_rdata.ls;
          res_nxt.rsrc   = 16'd0;
          res_nxt.rdst   = 16'd0;
        end
      end
      tsct_pkg::ACT_MISS: begin
        res_nxt        = res_zero;
        res_nxt.status = tsct_pkg::ST_UNKNOWN;
      end
      tsct_pkg::ACT_TICK: begin
        if (used_r[pidx_r] && ram_rdata.ls == tsct_pkg::LS_CLOSEWAIT) begin
          ram_we             = 1'b1;
          ram_wdata.wait_cnt = wait_inc;
          if (wait_inc > cfg_r) ram_wdata.ls = tsct_pkg::LS_CLOSED;
        end
      end
      tsct_pkg::ACT_TICK_DONE: begin
        res_nxt = res_zero;
      end
      tsct_pkg::ACT_UNKNOWN: begin
        res_nxt        = res_zero;
        res_nxt.status = tsct_pkg::ST_IGNORED;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> dv/transport_server_connection_table_checker.sv
// ----------------------------------------------------------------------------
// transport_server_connection_table_checker: result checker for the table
// Watches the request, result and configuration channels, keeps its own copy
// of the connection table and the close-wait limit, predicts the result of
// every accepted request and compares each delivered result against it.
// ----------------------------------------------------------------------------
module transport_server_connection_table_checker #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [2:0]  in_socket_index,
  input  logic [15:0] in_server_port,
  input  logic [2:0]  in_seg_type,
  input  logic [15:0] in_seg_src_port,
  input  logic [15:0] in_seg_dest_port,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [2:0]  out_entry_index,
  input  logic [1:0]  out_conn_state,
  input  logic        out_reply_valid,
  input  logic        out_reply_type,
  input  logic [15:0] out_reply_src_port,
  input  logic [15:0] out_reply_dest_port,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  logic            slot_used [ENTRIES];
  tsct_pkg::link_t slot_link [ENTRIES];
  logic [15:0]     slot_port [ENTRIES];
  logic [15:0]     slot_wait [ENTRIES];
  logic [15:0]     wait_limit;

  tsct_pkg::res_t expected_results[$];
  int             result_num;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h, expected %0h", result_num, what, got, want);
    errors++;
  endtask

  // Applies one request to the shadow table and returns the result it causes.
  task automatic apply_request(input logic [2:0] op, input logic [2:0] sidx,
                               input logic [15:0] sport, input logic [2:0] stype,
                               input logic [15:0] src, input logic [15:0] dst,
                               output tsct_pkg::res_t r);
    int i;
    int hit;
    r = '0;
    hit = -1;
    case (op)
      tsct_pkg::OP_CREATE: begin
        for (i = 0; i < ENTRIES; i++)
          if (!slot_used[i] && hit < 0) hit = i;
        if (hit < 0) begin
          r.status = tsct_pkg::ST_TABLE_FULL;
        end else begin
          slot_used[hit] = 1'b1;
          slot_link[hit] = tsct_pkg::LS_CLOSED;
          slot_port[hit] = sport;
          slot_wait[hit] = '0;
          r.status = tsct_pkg::ST_OK;
          r.idx = 3'(hit);
          r.cs = tsct_pkg::LS_CLOSED;
        end
      end
      tsct_pkg::OP_ACCEPT, tsct_pkg::OP_CLOSE: begin
        r.idx = sidx;
        if (int'(sidx) >= ENTRIES || !slot_used[sidx]) begin
          r.status = tsct_pkg::ST_UNUSED_SOCK;
        end else if (op == tsct_pkg::OP_ACCEPT) begin
          slot_link[sidx] = tsct_pkg::LS_LISTENING;
          r.status = tsct_pkg::ST_OK;
          r.cs = tsct_pkg::LS_LISTENING;
        end else begin
          if (slot_link[sidx] == tsct_pkg::LS_CLOSED) r.status = tsct_pkg::ST_OK;
          else r.status = tsct_pkg::ST_WRONG_STATE;
          slot_used[sidx] = 1'b0;
          slot_link[sidx] = tsct_pkg::LS_CLOSED;
          slot_wait[sidx] = '0;
          r.cs = tsct_pkg::LS_CLOSED;
        end
      end
      tsct_pkg::OP_SEGMENT: begin
        for (i = 0; i < ENTRIES; i++)
          if (slot_used[i] && slot_port[i] == dst && hit < 0) hit = i;
        if (hit < 0) begin
          r.status = tsct_pkg::ST_UNKNOWN;
        end else begin
          r.idx = 3'(hit);
          if ((slot_link[hit] == tsct_pkg::LS_LISTENING ||
               slot_link[hit] == tsct_pkg::LS_CONNECTED) &&
              stype == tsct_pkg::SEG_SYN) begin
            slot_link[hit] = tsct_pkg::LS_CONNECTED;
            r.status = tsct_pkg::ST_OK;
            r.cs = tsct_pkg::LS_CONNECTED;
            r.rv = 1'b1;
            r.rt = tsct_pkg::REPLY_SYNACK;
            r.rsrc = slot_port[hit];
            r.rdst = src;
          end else if ((slot_link[hit] == tsct_pkg::LS_CONNECTED ||
                        slot_link[hit] == tsct_pkg::LS_CLOSEWAIT) &&
                       stype == tsct_pkg::SEG_FIN) begin
            // Only the first FIN restarts the close-wait count.
            if (slot_link[hit] == tsct_pkg::LS_CONNECTED) slot_wait[hit] = '0;
            slot_link[hit] = tsct_pkg::LS_CLOSEWAIT;
            r.status = tsct_pkg::ST_OK;
            r.cs = tsct_pkg::LS_CLOSEWAIT;
            r.rv = 1'b1;
            r.rt = tsct_pkg::REPLY_FINACK;
            r.rsrc = slot_port[hit];
            r.rdst = src;
          end else begin
            r.status = tsct_pkg::ST_IGNORED;
            r.cs = slot_link[hit];
          end
        end
      end
      tsct_pkg::OP_TICK: begin
        for (i = 0; i < ENTRIES; i++) begin
          if (slot_used[i] && slot_link[i] == tsct_pkg::LS_CLOSEWAIT) begin
            if (slot_wait[i] != tsct_pkg::WAIT_MAX) slot_wait[i] = slot_wait[i] + 16'd1;
            if (slot_wait[i] > wait_limit) slot_link[i] = tsct_pkg::LS_CLOSED;
          end
        end
        r.status = tsct_pkg::ST_OK;
      end
      default: r.status = tsct_pkg::ST_IGNORED;
    endcase
  endtask

  always @(posedge clk) begin
    tsct_pkg::res_t want;
    tsct_pkg::res_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_link[i] = tsct_pkg::LS_CLOSED;
        slot_port[i] = '0;
        slot_wait[i] = '0;
      end
      wait_limit = 16'd1;
      expected_results.delete();
      result_num = 0;
    end else begin
      if (cfg_valid && cfg_ready) wait_limit = cfg_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("arrived with no request pending, status", 32'(out_status), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            flag_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_entry_index !== want.idx)
            flag_mismatch("entry_index", 32'(out_entry_index), 32'(want.idx));
          if (out_conn_state !== want.cs)
            flag_mismatch("conn_state", 32'(out_conn_state), 32'(want.cs));
          if (out_reply_valid !== want.rv)
            flag_mismatch("reply_valid", 32'(out_reply_valid), 32'(want.rv));
          if (out_reply_type !== want.rt)
            flag_mismatch("reply_type", 32'(out_reply_type), 32'(want.rt));
          if (out_reply_src_port !== want.rsrc)
            flag_mismatch("reply_src_port", 32'(out_reply_src_port), 32'(want.rsrc));
          if (out_reply_dest_port !== want.rdst)
            flag_mismatch("reply_dest_port", 32'(out_reply_dest_port), 32'(want.rdst));
        end
        result_num++;
      end
      if (in_valid && !in_stall) begin
        apply_request(in_operation, in_socket_index, in_server_port, in_seg_type,
                      in_seg_src_port, in_seg_dest_port, fresh);
        expected_results.push_back(fresh);
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> dv/transport_server_connection_table_tb.sv
// ----------------------------------------------------------------------------
// transport_server_connection_table_tb: testbench top for the table
// Drives a directed opening and then random connection sessions mixed with
// random requests, across several close-wait limits and idle patterns on
// both channels. The checker beside the block predicts and compares; this
// module gives the final verdict.
// ----------------------------------------------------------------------------
module transport_server_connection_table_tb;

  localparam int ENTRIES       = 8;
  localparam int ITEMS         = 1900;
  localparam int PHASES        = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  sidx;
    logic [15:0] sport;
    logic [2:0]  stype;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] seq;
  } req_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [2:0]  in_socket_index = '0;
  logic [15:0] in_server_port = '0;
  logic [2:0]  in_seg_type = '0;
  logic [15:0] in_seg_src_port = '0;
  logic [15:0] in_seg_dest_port = '0;
  logic [31:0] in_seg_seq = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_entry_index;
  logic [1:0]  out_conn_state;
  logic        out_reply_valid;
  logic        out_reply_type;
  logic [15:0] out_reply_src_port;
  logic [15:0] out_reply_dest_port;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int error_count;
  int pending_count;
  int cycle_count = 0;
  int requests_sent = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;

  // Used bits as the stimulus sees them, so sessions can address their entry.
  logic [ENTRIES-1:0] busy_mask = '0;
  logic [15:0]        last_port = '0;

  transport_server_connection_table #(.ENTRIES(ENTRIES)) i_dut (.*);

  transport_server_connection_table_checker #(.ENTRIES(ENTRIES)) i_checker (
    .errors (error_count),
    .pending(pending_count),
    .*
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < out_stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int first_free(input logic [ENTRIES-1:0] mask);
    int k;
    k = -1;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (!mask[i]) k = i;
    return k;
  endfunction

  function automatic req_t make_req(input logic [2:0] op, input logic [2:0] sidx,
                                    input logic [15:0] sport, input logic [2:0] stype,
                                    input logic [15:0] src, input logic [15:0] dst,
                                    input logic [31:0] seq);
    req_t r;
    r.op = op;
    r.sidx = sidx;
    r.sport = sport;
    r.stype = stype;
    r.src = src;
    r.dst = dst;
    r.seq = seq;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.op = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    r.sidx = 3'($urandom_range(7));
    r.sport = 16'($urandom);
    r.stype = 3'($urandom_range(7));
    r.src = 16'($urandom);
    r.dst = $urandom_range(1) ? last_port : 16'($urandom);
    r.seq = $urandom;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send(input req_t r);
    int k;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= r.op;
    in_socket_index <= r.sidx;
    in_server_port <= r.sport;
    in_seg_type <= r.stype;
    in_seg_src_port <= r.src;
    in_seg_dest_port <= r.dst;
    in_seg_seq <= r.seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    case (r.op)
      tsct_pkg::OP_CREATE: begin
        k = first_free(busy_mask);
        if (k >= 0) busy_mask[k] = 1'b1;
      end
      tsct_pkg::OP_CLOSE: busy_mask[r.sidx] = 1'b0;
      default: ;
    endcase
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One connection lifetime on a fresh port, with steps dropped at random.
  task automatic run_session();
    req_t        r;
    logic [15:0] p;
    int          k;
    int          n;
    p = 16'($urandom);
    last_port = p;
    k = first_free(busy_mask);
    if (k < 0) k = $urandom_range(ENTRIES - 1);
    r = rand_req();
    r.op = tsct_pkg::OP_CREATE;
    r.sport = p;
    send(r);
    if ($urandom_range(9) != 0) begin
      r = rand_req();
      r.op = tsct_pkg::OP_ACCEPT;
      r.sidx = 3'(k);
      send(r);
    end
    n = $urandom_range(2, 1);
    repeat (n) begin
      r = rand_req();
      r.op = tsct_pkg::OP_SEGMENT;
      r.stype = tsct_pkg::SEG_SYN;
      r.dst = p;
      send(r);
    end
    if ($urandom_range(9) < 8) begin
      n = $urandom_range(2, 1);
      repeat (n) begin
        r = rand_req();
        r.op = tsct_pkg::OP_SEGMENT;
        r.stype = tsct_pkg::SEG_FIN;
        r.dst = p;
        send(r);
      end
    end
    n = $urandom_range(6);
    repeat (n) begin
      r = rand_req();
      r.op = tsct_pkg::OP_TICK;
      send(r);
    end
    if ($urandom_range(3) == 0) begin
      r = rand_req();
      r.op = tsct_pkg::OP_SEGMENT;
      r.dst = p;
      send(r);
    end
    if ($urandom_range(9) < 8) begin
      r = rand_req();
      r.op = tsct_pkg::OP_CLOSE;
      r.sidx = 3'(k);
      send(r);
    end
  endtask

  initial begin
    logic [15:0] limit;
    int          phase_end;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening, run with the reset close-wait limit of one tick.
    send(make_req(tsct_pkg::OP_SEGMENT, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'h1234,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_ACCEPT, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CLOSE, 3'd7, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd0, 16'hFFFF, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd0, 16'h0001, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd0, 16'h0002, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd0, 16'h0003, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd0, 16'h0004, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd0, 16'h0005, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd0, 16'h8000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CREATE, 3'd7, 16'h7777, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_SEGMENT, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'h0042,
                  16'hFFFF, 32'd5));
    send(make_req(tsct_pkg::OP_ACCEPT, 3'd1, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_SEGMENT, 3'd0, 16'h0000, tsct_pkg::SEG_FIN, 16'h0042,
                  16'hFFFF, 32'd6));
    send(make_req(tsct_pkg::OP_SEGMENT, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'hFFFF,
                  16'hFFFF, 32'hFFFFFFFF));
    send(make_req(tsct_pkg::OP_SEGMENT, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'hFFFF, 32'd0));
    send(make_req(tsct_pkg::OP_SEGMENT, 3'd0, 16'h0000, 3'd7, 16'h0042,
                  16'hFFFF, 32'd1));
    send(make_req(tsct_pkg::OP_SEGMENT, 3'd0, 16'h0000, tsct_pkg::SEG_FIN, 16'hABCD,
                  16'hFFFF, 32'd2));
    send(make_req(tsct_pkg::OP_SEGMENT, 3'd0, 16'h0000, tsct_pkg::SEG_FIN, 16'hABCD,
                  16'hFFFF, 32'd3));
    send(make_req(tsct_pkg::OP_TICK, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_TICK, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(3'd7, 3'd7, 16'hFFFF, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF));
    send(make_req(tsct_pkg::OP_CLOSE, 3'd1, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_ACCEPT, 3'd2, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CLOSE, 3'd2, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));
    send(make_req(tsct_pkg::OP_CLOSE, 3'd0, 16'h0000, tsct_pkg::SEG_SYN, 16'h0000,
                  16'h0000, 32'd0));

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: limit = 16'd0;
        1: limit = 16'hFFFF;
        2: limit = 16'd3;
        3: limit = 16'($urandom_range(6));
        4: limit = 16'd2;
        5: limit = 16'hFFFF;
        6: limit = 16'd0;
        default: limit = 16'($urandom);
      endcase
      write_limit(limit);
      case (phase % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 86; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 86; end
        default: begin in_idle_pct = 7; out_stall_pct = 7; end
      endcase
      phase_end = ITEMS * (phase + 1) / PHASES;
      while (requests_sent < phase_end) begin
        if ($urandom_range(99) < 65) run_session();
        else send(rand_req());
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/tsct_pkg.sv
design/tsct_ram.sv
design/tsct_ctrl.sv
design/tsct_dp.sv
design/transport_server_connection_table.sv
dv/transport_server_connection_table_checker.sv
dv/transport_server_connection_table_tb.sv
